// ===== hdl/assert_macros.svh =====
// assertion helpers included by the decoder unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is low
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// implication checked at every rising edge, masked while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int SIZE_BITS_DEF = 31;
  localparam int HEX_BITS      = 4;
  localparam int TRAIL_BITS    = 2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [TRAIL_BITS-1:0] TRAILER_BYTES = 2'd2;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_WS      = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_REST    = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic                is_hex;
    logic [HEX_BITS-1:0] value;
  } hex_t;

  // hex digit decode, either case
  function automatic hex_t hex_decode(byte_t c);
    hex_t h;
    h.is_hex = 1'b0;
    h.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.is_hex = 1'b1;
      h.value  = HEX_BITS'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.is_hex = 1'b1;
      h.value  = HEX_BITS'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.is_hex = 1'b1;
      h.value  = HEX_BITS'(c - 8'h57);
    end
    return h;
  endfunction

endpackage

// ===== hdl/hcbd_if.sv =====
interface hcbd_in_if;
  import hcbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface hcbd_out_if;
  import hcbd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  is_end;

  modport source (output valid, output out_byte, output is_end, input ready);
  modport sink   (input valid, input out_byte, input is_end, output ready);
endinterface

// ===== hdl/http_chunked_body_decoder_unit.sv =====
// channel  | direction | payload                  | request taken when
// in_chan  | in        | in_byte[7:0], new_stream | in_chan.valid && in_chan.ready
// out_chan | out       | out_byte[7:0], is_end    | out_chan.valid && out_chan.ready
//
// one byte per cycle sustained while out_chan is not stalled; a taken request is held
// in the input register, is decoded on its way into the result register and shows on
// out_chan from the result register
// the header/payload state loop is a single register stage, so it sets the rate
// reset (rst_n low, synchronous) puts the parser in the header whitespace phase
// a stall on out_chan holds the decode stage; in_chan keeps taking a request
// as long as the input register drains in the same cycle
module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hcbd_in_if.sink     in_chan,
  hcbd_out_if.source  out_chan
);
  import hcbd_pkg::*;

  localparam int ACC_BITS = SIZE_BITS + HEX_BITS;

  // input register
  logic  in_vld_r;
  byte_t in_byte_r;
  logic  in_new_r;

  // parser state
  phase_t                phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]  cnt_r, cnt_nxt;
  logic [TRAIL_BITS-1:0] trail_r, trail_nxt;

  // result register
  logic  out_vld_r;
  byte_t out_byte_r;
  logic  out_end_r;

  // decode stage moves whenever the result slot is free or being emptied
  logic stage_adv;
  logic in_take;

  // state seen by the current byte, after a possible stream restart
  phase_t                phase_cur;
  logic [SIZE_BITS-1:0]  cnt_cur;
  logic [TRAIL_BITS-1:0] trail_cur;

  hex_t                  hex;
  logic [ACC_BITS-1:0]   acc_wide;
  logic [SIZE_BITS-1:0]  acc_sat;
  logic                  is_ws;

  // result of the decode stage
  logic  res_vld;
  byte_t res_byte;
  logic  res_end;

  assign stage_adv     = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || stage_adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  assign phase_cur = in_new_r ? PH_WS : phase_r;
  assign cnt_cur   = in_new_r ? '0 : cnt_r;
  assign trail_cur = in_new_r ? '0 : trail_r;

  assign hex   = hex_decode(in_byte_r);
  assign is_ws = (in_byte_r == CH_SPACE) || (in_byte_r == CH_TAB);

  // size * 16 + digit, saturating at all ones
  assign acc_wide = {{HEX_BITS{1'b0}}, cnt_cur} << HEX_BITS | ACC_BITS'(hex.value);
  assign acc_sat  = (acc_wide[ACC_BITS-1 -: HEX_BITS] != '0) ? '1
                                                              : acc_wide[SIZE_BITS-1:0];

  // next state
  always_comb begin
    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    trail_nxt = trail_cur;
    unique case (phase_cur)
      PH_WS: begin
        if (in_byte_r == CH_NEWLINE) begin
          phase_nxt = (cnt_cur == '0) ? PH_DONE : PH_PAYLOAD;
        end else if (!is_ws) begin
          if (hex.is_hex) begin
            cnt_nxt   = acc_sat;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_REST;
          end
        end
      end
      PH_DIGITS: begin
        if (in_byte_r == CH_NEWLINE) begin
          phase_nxt = (cnt_cur == '0) ? PH_DONE : PH_PAYLOAD;
        end else if (hex.is_hex) begin
          cnt_nxt = acc_sat;
        end else begin
          phase_nxt = PH_REST;
        end
      end
      PH_REST: begin
        if (in_byte_r == CH_NEWLINE) begin
          phase_nxt = (cnt_cur == '0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        // last payload byte when the count is at most one
        if (cnt_cur != '0) begin
          cnt_nxt = cnt_cur - SIZE_BITS'(1);
        end
        if (cnt_cur <= SIZE_BITS'(1)) begin
          phase_nxt = PH_TRAILER;
          trail_nxt = TRAILER_BYTES;
        end
      end
      PH_TRAILER: begin
        if (trail_cur != '0) begin
          trail_nxt = trail_cur - TRAIL_BITS'(1);
        end
        if (trail_cur <= TRAIL_BITS'(1)) begin
          phase_nxt = PH_WS;
          cnt_nxt   = '0;
        end
      end
      default: begin
        // done, and unused codes: ignore everything
      end
    endcase
  end

  // outputs of the decode stage
  always_comb begin
    res_vld  = 1'b0;
    res_byte = '0;
    res_end  = 1'b0;
    unique case (phase_cur) inside
      PH_WS, PH_DIGITS, PH_REST: begin
        // zero-size header line ends the stream
        if (in_byte_r == CH_NEWLINE && cnt_cur == '0) begin
          res_vld = 1'b1;
          res_end = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        res_vld  = 1'b1;
        res_byte = in_byte_r;
      end
      default: begin
      end
    endcase
  end

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.in_byte;
      in_new_r  <= in_chan.new_stream;
    end
  end

  // parser state advances once per decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      cnt_r   <= '0;
      trail_r <= '0;
    end else if (in_vld_r && stage_adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      trail_r <= trail_nxt;
    end
  end

  // result register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_adv) begin
      out_vld_r <= in_vld_r && res_vld;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (stage_adv && in_vld_r && res_vld) begin
      out_byte_r <= res_byte;
      out_end_r  <= res_end;
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.is_end   = out_end_r;

  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_end_zero, clk, rst_n, out_vld_r && out_end_r,
                  out_byte_r == '0, "end result carries a nonzero byte")
  `ASSERT_IMPLIES(a_payload_cnt, clk, rst_n, phase_r == PH_PAYLOAD,
                  cnt_r != '0, "payload phase with zero count")
  `ASSERT_IMPLIES(a_trailer_left, clk, rst_n, phase_r == PH_TRAILER,
                  trail_r != '0, "trailer phase with nothing left")
  `ASSERT_ALWAYS(a_no_result_done, clk, rst_n,
                 !(in_vld_r && !in_new_r && phase_r == PH_DONE && res_vld),
                 "result produced after end of stream")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hcbd_pkg::*;

  localparam int SIZE_BITS    = SIZE_BITS_DEF;
  localparam int RANDOM_BYTES = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  typedef struct packed {
    byte_t data;
    logic  restart;
  } body_byte_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hcbd_in_if  in_chan ();
  hcbd_out_if out_chan ();

  http_chunked_body_decoder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // body bytes waiting to be sent, and decoded bytes we still expect back
  body_byte_t body_q[$];
  decoded_t   decoded_q[$];

  // shadow copy of the parser state
  phase_t               dec_phase  = PH_WS;
  logic [SIZE_BITS-1:0] chunk_left = '0;
  logic [TRAIL_BITS-1:0] crlf_left = '0;

  int n_cycles   = 0;
  int n_errors   = 0;
  int n_total    = 0;
  int n_accepted = 0;
  int n_payload  = 0;
  int n_ends     = 0;
  int n_streams  = 0;
  int send_gap   = 0;
  int send_calm  = 0;
  int stall_left = 0;
  int stall_calm = 0;
  bit took;
  bit stream_start;
  logic long_hold = 1'b0;
  decoded_t want;

  initial begin
    in_chan.valid      = 1'b0;
    in_chan.in_byte    = '0;
    in_chan.new_stream = 1'b0;
    out_chan.ready     = 1'b0;
  end

  function automatic int hex_digit(byte_t c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // steps the shadow parser by one body byte and queues what it gives out
  function automatic void decode_byte(byte_t c, logic restart);
    int d;
    longint unsigned acc;
    if (restart) begin
      dec_phase  = PH_WS;
      chunk_left = '0;
      crlf_left  = '0;
    end
    d = hex_digit(c);
    case (dec_phase)
      PH_WS, PH_DIGITS, PH_REST: begin
        if (c == CH_NEWLINE) begin
          // header line done; zero size means end of body
          if (chunk_left == '0) begin
            dec_phase = PH_DONE;
            decoded_q.push_back('{data: 8'h00, last: 1'b1});
          end else begin
            dec_phase = PH_PAYLOAD;
          end
        end else if (dec_phase == PH_WS && (c == CH_SPACE || c == CH_TAB)) begin
          dec_phase = PH_WS;
        end else if (dec_phase != PH_REST && d >= 0) begin
          acc = longint'(chunk_left) * 16 + longint'(d);
          chunk_left = (acc > longint'(SIZE_MAX)) ? SIZE_MAX : acc[SIZE_BITS-1:0];
          dec_phase  = PH_DIGITS;
        end else begin
          // anything else, "0x", signs and cr included, ends the digits
          dec_phase = PH_REST;
        end
      end
      PH_PAYLOAD: begin
        decoded_q.push_back('{data: c, last: 1'b0});
        if (chunk_left != '0) chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          dec_phase = PH_TRAILER;
          crlf_left = TRAILER_BYTES;
        end
      end
      PH_TRAILER: begin
        if (crlf_left != '0) crlf_left = crlf_left - 1'b1;
        if (crlf_left == '0) begin
          dec_phase  = PH_WS;
          chunk_left = '0;
        end
      end
      default: begin
        // done: ignore until the next stream
      end
    endcase
  endfunction

  // mostly back to back, some short gaps, rare long ones, and calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", n_cycles, what);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_byte(byte_t c);
    body_q.push_back('{data: c, restart: stream_start});
    stream_start = 1'b0;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic begin_stream();
    stream_start = 1'b1;
    n_streams++;
  endtask

  // header line: optional blanks, hex size in mixed case, optional extension
  task automatic add_header(int size);
    string hex;
    byte_t ch;
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    if (size == 0) begin
      case ($urandom_range(0, 3))
        0:       push_text("0");
        1:       push_text("000");
        2:       push_text("-1");
        default: ; // bare newline also means zero
      endcase
    end else begin
      repeat ($urandom_range(0, 2)) push_text("0");
      hex = $sformatf("%0h", size);
      for (int i = 0; i < hex.len(); i++) begin
        ch = hex[i];
        if (ch >= "a" && $urandom_range(0, 1)) ch = ch - 8'd32;
        push_byte(ch);
      end
    end
    if ($urandom_range(0, 4) == 0) push_text(";ext=v");
    if ($urandom_range(0, 4) != 0) push_text("\r");
    push_byte(CH_NEWLINE);
  endtask

  // one chunked body with random payload; sometimes cut short
  task automatic add_stream();
    int n_chunks;
    int size;
    int cut;
    begin_stream();
    // now and then no restart, so the bytes land on whatever state is left
    if ($urandom_range(0, 9) == 0) stream_start = 1'b0;
    n_chunks = $urandom_range(1, 4);
    for (int k = 0; k < n_chunks; k++) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 90) : $urandom_range(1, 16);
      add_header(size);
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, size - 1) : size;
      for (int i = 0; i < cut; i++) push_byte($urandom_range(0, 255));
      if (cut < size) return;
      if ($urandom_range(0, 5) == 0) begin
        push_byte($urandom_range(0, 255));
        push_byte($urandom_range(0, 255));
      end else begin
        push_text("\r\n");
      end
    end
    add_header(0);
    // trailing bytes after the end are ignored
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) push_byte($urandom_range(0, 255));
  endtask

  task automatic add_noise();
    repeat ($urandom_range(4, 20)) begin
      stream_start = ($urandom_range(0, 7) == 0);
      push_byte($urandom_range(0, 255));
    end
  endtask

  task automatic build_stimulus();
    int n_directed;
    // a blank and a tab before the size, cr before newline, a second chunk holding
    // a zero byte, then zero chunk and a byte after the end
    begin_stream();
    push_text(" \t1\r\nA\r\n");
    push_text("1\n");
    push_byte(8'h00);
    push_text("\r\n0\nx");
    // hex prefix is not honored: size zero
    begin_stream();
    push_text("0x\n");
    // newline before any digit
    begin_stream();
    push_byte(CH_NEWLINE);
    // leading sign ends the digits
    begin_stream();
    push_text("+7\n");
    // oversized header saturates, then the stream is cut off
    begin_stream();
    push_text("aFFFFFFFF\n");
    push_byte(8'hFF);
    push_byte(8'h00);
    n_directed = body_q.size();
    while (body_q.size() < n_directed + RANDOM_BYTES) begin
      if ($urandom_range(0, 19) == 0) add_noise();
      else add_stream();
    end
    n_total = body_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers body bytes, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      took = in_chan.valid && in_chan.ready;
      if (took) begin
        decode_byte(in_chan.in_byte, in_chan.new_stream);
        n_accepted++;
      end
      if (!in_chan.valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (body_q.size() > 0) begin
          in_chan.in_byte    <= body_q[0].data;
          in_chan.new_stream <= body_q[0].restart;
          in_chan.valid      <= 1'b1;
          void'(body_q.pop_front());
          send_gap = pick_gap(send_calm);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure, compares each decoded byte in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h end %0b",
                                    out_chan.out_byte, out_chan.is_end));
        end else begin
          want = decoded_q.pop_front();
          if (out_chan.out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_chan.out_byte, want.data));
          if (out_chan.is_end !== want.last)
            report_mismatch($sformatf("is_end %0b, expected %0b",
                                      out_chan.is_end, want.last));
          if (want.last) n_ends++;
          else n_payload++;
        end
      end
      if (long_hold) begin
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        stall_left = pick_gap(stall_calm);
      end
    end
  end

  // long receiver hold-off while payload is flowing, so the input backs up
  initial begin
    while (n_accepted < 150 || decoded_q.size() == 0) @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d body bytes over %0d streams plus noise, with a %0d-cycle output hold",
             n_accepted, n_streams, HOLD_CYCLES);
    $display("checked %0d payload bytes and %0d end markers", n_payload, n_ends);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
